// ===== rtl/core/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// TLB page table translator package
// Shared sizes, result codes and controller command type.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	localparam int TLB_ENTRIES = 16;
	localparam int PAGE_COUNT  = 256;
	localparam int FRAME_BYTES = 256;

	localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
	localparam int PAGE_W    = $clog2(PAGE_COUNT);
	localparam int OFFSET_W  = $clog2(FRAME_BYTES);
	localparam int FRAME_W   = 8;
	localparam int VADDR_W   = 16;
	localparam int PADDR_W   = 16;
	localparam int COUNT_W   = 32;
	localparam int OUTCOME_W = 2;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_TLB_HIT   = 2'd0,
		OUT_TABLE_HIT = 2'd1,
		OUT_FAULT     = 2'd2
	} outcome_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} tlbpt_cmd_t;

endpackage

// ===== rtl/core/tlbpt_req_if.sv =====
// ----------------------------------------------------------------------------
// Translation request channel
// Valid/ready channel that carries one virtual address per item.
// ----------------------------------------------------------------------------
interface tlbpt_req_if
	import tlbpt_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [VADDR_W-1:0] virtual_address;

	modport source (output valid, output virtual_address, input ready);
	modport sink (input valid, input virtual_address, output ready);
endinterface

// ===== rtl/core/tlbpt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Translation response channel
// Valid/ready channel that carries one translation result per item.
// ----------------------------------------------------------------------------
interface tlbpt_rsp_if
	import tlbpt_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [PADDR_W-1:0]   physical_address;
	logic [OUTCOME_W-1:0] outcome;
	logic [COUNT_W-1:0]   hits_so_far;
	logic [COUNT_W-1:0]   faults_so_far;
	logic [COUNT_W-1:0]   accesses_so_far;

	modport source (
		output valid, output physical_address, output outcome,
		output hits_so_far, output faults_so_far, output accesses_so_far,
		input ready
	);
	modport sink (
		input valid, input physical_address, input outcome,
		input hits_so_far, input faults_so_far, input accesses_so_far,
		output ready
	);
endinterface

// ===== rtl/core/tlbpt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/core/tlbpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Translator controller
// Sequences capture and commit of one item and owns the result valid flag.
// ----------------------------------------------------------------------------
module tlbpt_ctrl
	import tlbpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output tlbpt_cmd_t cmd
);
	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   commit;

	assign req_ready   = (state_q == ST_IDLE);
	assign commit      = (state_q == ST_LOOKUP) && (!rsp_valid_q || rsp_ready);
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = commit;
	assign rsp_valid   = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/core/tlbpt_datapath.sv =====
// ----------------------------------------------------------------------------
// Translator datapath
// TLB registers, page table memory with valid bits, counters, result register.
// ----------------------------------------------------------------------------
module tlbpt_datapath
	import tlbpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlbpt_cmd_t           cmd,
	input  logic [VADDR_W-1:0]   virtual_address,
	output logic [PADDR_W-1:0]   physical_address,
	output logic [OUTCOME_W-1:0] outcome,
	output logic [COUNT_W-1:0]   hits_so_far,
	output logic [COUNT_W-1:0]   faults_so_far,
	output logic [COUNT_W-1:0]   accesses_so_far
);
	logic [VADDR_W-1:0]   va_q;
	logic [PAGE_W-1:0]    tlb_tag_q [TLB_ENTRIES];
	logic [FRAME_W-1:0]   tlb_frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tlb_valid_q;
	logic [PAGE_COUNT-1:0]  table_valid_q;
	logic [TLB_IDX_W-1:0] victim_q;
	logic [FRAME_W-1:0]   free_frame_q;
	logic [COUNT_W-1:0]   hit_cnt_q;
	logic [COUNT_W-1:0]   fault_cnt_q;
	logic [COUNT_W-1:0]   access_cnt_q;
	logic [PADDR_W-1:0]   paddr_q;
	outcome_t             outcome_q;

	logic [PAGE_W-1:0]    page;
	logic [OFFSET_W-1:0]  offset;
	logic [PAGE_W-1:0]    raddr;
	logic [FRAME_W-1:0]   table_frame;
	logic                 tlb_hit;
	logic [TLB_IDX_W-1:0] hit_idx;
	logic                 table_hit;
	logic                 fault;
	logic [FRAME_W-1:0]   frame;
	outcome_t             result;

	assign page   = va_q[VADDR_W-1 -: PAGE_W];
	assign offset = va_q[OFFSET_W-1:0];
	assign raddr  = cmd.capture ? virtual_address[VADDR_W-1 -: PAGE_W] : page;

	tlbpt_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (PAGE_COUNT)
	) u_table (
		.clk   (clk),
		.we    (cmd.commit && fault),
		.waddr (page),
		.wdata (free_frame_q),
		.raddr (raddr),
		.rdata (table_frame)
	);

	always_comb begin
		tlb_hit = 1'b0;
		hit_idx = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tlb_valid_q[i] && (tlb_tag_q[i] == page)) begin
				tlb_hit = 1'b1;
				hit_idx = TLB_IDX_W'(i);
			end
		end
	end

	assign table_hit = table_valid_q[page];
	assign fault     = !tlb_hit && !table_hit;

	always_comb begin
		if (tlb_hit) begin
			frame  = tlb_frame_q[hit_idx];
			result = OUT_TLB_HIT;
		end else if (table_hit) begin
			frame  = table_frame;
			result = OUT_TABLE_HIT;
		end else begin
			frame  = free_frame_q;
			result = OUT_FAULT;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			va_q <= virtual_address;
		end
		if (cmd.commit) begin
			paddr_q   <= {frame, offset};
			outcome_q <= result;
			if (!tlb_hit) begin
				tlb_tag_q[victim_q]   <= page;
				tlb_frame_q[victim_q] <= frame;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlb_valid_q   <= '0;
			table_valid_q <= '0;
			victim_q      <= '0;
			free_frame_q  <= '0;
			hit_cnt_q     <= '0;
			fault_cnt_q   <= '0;
			access_cnt_q  <= '0;
		end else if (cmd.commit) begin
			if (access_cnt_q != '1) begin
				access_cnt_q <= access_cnt_q + COUNT_W'(1);
			end
			if (tlb_hit) begin
				if (hit_cnt_q != '1) begin
					hit_cnt_q <= hit_cnt_q + COUNT_W'(1);
				end
			end else begin
				tlb_valid_q[victim_q] <= 1'b1;
				victim_q <= (victim_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
				            '0 : victim_q + TLB_IDX_W'(1);
			end
			if (fault) begin
				table_valid_q[page] <= 1'b1;
				free_frame_q        <= free_frame_q + FRAME_W'(1);
				if (fault_cnt_q != '1) begin
					fault_cnt_q <= fault_cnt_q + COUNT_W'(1);
				end
			end
		end
	end

	assign physical_address = paddr_q;
	assign outcome          = outcome_q;
	assign hits_so_far      = hit_cnt_q;
	assign faults_so_far    = fault_cnt_q;
	assign accesses_so_far  = access_cnt_q;
endmodule

// ===== rtl/core/tlb_page_table_translator.sv =====
// ----------------------------------------------------------------------------
// TLB page table translator
// Translates a 16-bit virtual address through a 16-entry FIFO TLB backed by
// a 256-entry demand-paged page table.
// ----------------------------------------------------------------------------
// A translation starts in the accept cycle with the page table memory read.
// In the lookup state, once the result register is free or its result is
// being taken, the block compares all TLB tags, takes the registered table
// entry and commits TLB, table and counter updates while loading the result
// register. The next request is accepted right after the commit, even while
// the previous result is still waiting; its commit then waits for that
// result to be taken. Valid bits clear at reset, so no clearing pass is run.
module tlb_page_table_translator
	import tlbpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tlbpt_req_if.sink   req,
	tlbpt_rsp_if.source rsp
);
	tlbpt_cmd_t cmd;

	tlbpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	tlbpt_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.virtual_address  (req.virtual_address),
		.physical_address (rsp.physical_address),
		.outcome          (rsp.outcome),
		.hits_so_far      (rsp.hits_so_far),
		.faults_so_far    (rsp.faults_so_far),
		.accesses_so_far  (rsp.accesses_so_far)
	);
endmodule

// ===== rtl/core/tlbpt_checker.sv =====
// ----------------------------------------------------------------------------
// Translator port checker
// Port-level properties of the translator, bound to the top level.
// ----------------------------------------------------------------------------
module tlbpt_checker
	import tlbpt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [COUNT_W-1:0] hits_so_far,
	input logic [COUNT_W-1:0] faults_so_far,
	input logic [COUNT_W-1:0] accesses_so_far
);
	logic req_seen;
	assign req_seen = req_valid && req_ready;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (hits_so_far <= accesses_so_far) &&
		              (faults_so_far <= accesses_so_far))
		else $error("hit or fault count exceeds access count");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && (accesses_so_far != '1) |=>
		!rsp_valid || (accesses_so_far == $past(accesses_so_far) + COUNT_W'(1)))
		else $error("access count did not advance by one per item");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_seen |=> !req_ready)
		else $error("request taken while previous item still in lookup");
endmodule

bind tlb_page_table_translator tlbpt_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.hits_so_far     (rsp.hits_so_far),
	.faults_so_far   (rsp.faults_so_far),
	.accesses_so_far (rsp.accesses_so_far)
);
